// ===== design/bcc_pkg.sv =====
// Shared types, widths and constants for the button click/hold classifier.
package bcc_pkg;

    localparam int TICK_WIDTH   = 32;
    localparam int CFG_WIDTH    = 16;
    localparam int COUNT_WIDTH  = 16;
    localparam int CLICK_WIDTH  = 2;
    localparam int EVENT_WIDTH  = 2;
    localparam int CFG_ADDR_WIDTH = 2;

    // Input word: tick_now, then pin_level, padded to whole bytes.
    localparam int S_DATA_BITS  = TICK_WIDTH + 1;
    localparam int S_DATA_WIDTH = ((S_DATA_BITS + 7) / 8) * 8;
    // Result word: event_res, then stepped, padded to whole bytes.
    localparam int M_DATA_BITS  = EVENT_WIDTH + 1;
    localparam int M_DATA_WIDTH = ((M_DATA_BITS + 7) / 8) * 8;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 16'd60000;

    // Event codes
    localparam logic [EVENT_WIDTH-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_WIDTH-1:0] EV_SINGLE = 2'd1;
    localparam logic [EVENT_WIDTH-1:0] EV_DOUBLE = 2'd2;
    localparam logic [EVENT_WIDTH-1:0] EV_HOLD   = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_HOLD_TICKS       = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DEBOUNCE_TICKS   = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DOUBLE_GAP_TICKS = 2'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_PACE_INTERVAL    = 2'd3;

    // Register reset values
    localparam logic [CFG_WIDTH-1:0] HOLD_TICKS_RST       = 16'd500;
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TICKS_RST   = 16'd3;
    localparam logic [CFG_WIDTH-1:0] DOUBLE_GAP_TICKS_RST = 16'd30;
    localparam logic [CFG_WIDTH-1:0] PACE_INTERVAL_RST    = 16'd10;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] hold_ticks;
        logic [CFG_WIDTH-1:0] debounce_ticks;
        logic [CFG_WIDTH-1:0] double_gap_ticks;
        logic [CFG_WIDTH-1:0] pace_interval;
    } cfg_t;

    typedef struct packed {
        logic [TICK_WIDTH-1:0]  last_step_tick;
        logic [COUNT_WIDTH-1:0] press_count;
        logic [COUNT_WIDTH-1:0] release_count;
        logic [CLICK_WIDTH-1:0] clicks_pending;
    } state_t;

    typedef struct packed {
        logic [EVENT_WIDTH-1:0] event_res;
        logic                   stepped;
    } result_t;

endpackage

// ===== design/bcc_cfg_regs.sv =====
// Configuration register file of the button click/hold classifier.
module bcc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bcc_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [bcc_pkg::CFG_WIDTH-1:0] cfg_wdata,
    output bcc_pkg::cfg_t                 cfg
);
    import bcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HOLD_TICKS:       cfg_next.hold_ticks       = cfg_wdata;
                REG_DEBOUNCE_TICKS:   cfg_next.debounce_ticks   = cfg_wdata;
                REG_DOUBLE_GAP_TICKS: cfg_next.double_gap_ticks = cfg_wdata;
                REG_PACE_INTERVAL:    cfg_next.pace_interval    = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_ticks       <= HOLD_TICKS_RST;
            cfg_reg.debounce_ticks   <= DEBOUNCE_TICKS_RST;
            cfg_reg.double_gap_ticks <= DOUBLE_GAP_TICKS_RST;
            cfg_reg.pace_interval    <= PACE_INTERVAL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/bcc_step.sv =====
// Step logic: pacing check and press/release classification for one word.
module bcc_step (
    input  bcc_pkg::cfg_t                  cfg,
    input  bcc_pkg::state_t                state_cur,
    input  logic [bcc_pkg::TICK_WIDTH-1:0] tick_now,
    input  logic                           pin_level,
    output bcc_pkg::state_t                state_next,
    output bcc_pkg::result_t               result
);
    import bcc_pkg::*;

    logic [TICK_WIDTH-1:0]  tick_diff;
    logic                   run_step;
    logic [COUNT_WIDTH-1:0] press_inc;
    logic [COUNT_WIDTH-1:0] release_inc;
    logic [CLICK_WIDTH-1:0] clicks;

    assign tick_diff = tick_now - state_cur.last_step_tick;
    assign run_step  = tick_diff >= TICK_WIDTH'(cfg.pace_interval);
    assign press_inc = state_cur.press_count + 1'b1;

    always_comb begin
        state_next       = state_cur;
        result.event_res = EV_NONE;
        result.stepped   = run_step;
        clicks           = state_cur.clicks_pending;
        release_inc      = state_cur.release_count;

        if (run_step) begin
            state_next.last_step_tick = tick_now;
            if (!pin_level) begin
                // pressed: count up, raise hold on reaching the target
                state_next.release_count = '0;
                if (state_cur.press_count < COUNT_MAX) begin
                    state_next.press_count = press_inc;
                    if (press_inc == cfg.hold_ticks) begin
                        result.event_res          = EV_HOLD;
                        state_next.clicks_pending = '0;
                    end
                end
            end else begin
                // released: close out a press, then time the gap
                if (state_cur.press_count != '0) begin
                    if (state_cur.press_count > cfg.debounce_ticks &&
                        state_cur.press_count < cfg.hold_ticks) begin
                        clicks = state_cur.clicks_pending + 1'b1;
                    end
                    state_next.press_count = '0;
                end
                state_next.clicks_pending = clicks;
                if (clicks != '0) begin
                    if (state_cur.release_count < COUNT_MAX) begin
                        release_inc = state_cur.release_count + 1'b1;
                    end
                    state_next.release_count = release_inc;
                    if (clicks == CLICK_WIDTH'(2)) begin
                        result.event_res          = EV_DOUBLE;
                        state_next.clicks_pending = '0;
                        state_next.release_count  = '0;
                    end else if (release_inc > cfg.double_gap_ticks) begin
                        if (clicks == CLICK_WIDTH'(1)) begin
                            result.event_res = EV_SINGLE;
                        end
                        state_next.clicks_pending = '0;
                        state_next.release_count  = '0;
                    end
                end else begin
                    state_next.release_count = '0;
                end
            end
        end
    end

endmodule

// ===== design/button_click_hold_classifier_top.sv =====
// Top level of the button click/hold classifier: stream stages and state.
//
// Classifies presses of one active-low push button into single click,
// double click and hold events.
// Input channel (s_): each word carries the free-running tick count and the
// sampled pin level (0 pressed). Result channel (m_): one word per input
// word, with the event raised in that step and a flag that the step ran.
// Configuration: write cfg_wdata to register cfg_addr when cfg_wr_en is high
// (0 hold_ticks, 1 debounce_ticks, 2 double_gap_ticks, 3 pace_interval).
// Write only while no words are in flight.
// Path: an accepted input word passes the input register, then the result
// register. Throughput: one word per cycle while m_tready is high; the step
// logic between the two registers is a tick subtract/compare and a few
// 16-bit compares and increments.
// Reset (aresetn low, synchronous): both stages empty, classifier state
// cleared, registers back to their defaults.
// Stall: when m_tready is low the result register holds; the input register
// still takes one more word, after which s_tready drops until the result
// register frees up.
module button_click_hold_classifier_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] tick_now, [32] pin_level, rest zero
    input  logic [bcc_pkg::S_DATA_WIDTH-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] event_res, [2] stepped, rest zero
    output logic [bcc_pkg::M_DATA_WIDTH-1:0]    m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [bcc_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  logic [bcc_pkg::CFG_WIDTH-1:0]       cfg_wdata
);
    import bcc_pkg::*;

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;

    // input stage
    logic                  in_valid_reg;
    logic [TICK_WIDTH-1:0] in_tick_reg;
    logic                  in_pin_reg;

    // result stage
    logic    out_valid_reg;
    result_t out_res_reg;

    logic advance;
    logic s_accept;

    bcc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcc_step u_step (
        .cfg        (cfg),
        .state_cur  (state_reg),
        .tick_now   (in_tick_reg),
        .pin_level  (in_pin_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Move the input word into the result register when that slot is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_tick_reg <= s_tdata[TICK_WIDTH-1:0];
            in_pin_reg  <= s_tdata[TICK_WIDTH];
        end
    end

    // Commit classifier state only when the step's result is captured.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_WIDTH - M_DATA_BITS){1'b0}},
                       out_res_reg.stepped, out_res_reg.event_res};

endmodule

// ===== bench/tb.sv =====
// Self-checking stream testbench for the button click/hold classifier.
module tb;
    import bcc_pkg::*;

    // Paced steps to run in the random part, spread over the register settings.
    localparam int TARGET_STEPS = 1030;
    localparam int PHASES       = 9;
    // Idle cycles before a register write: covers the input and result stages.
    localparam int SETTLE       = 4;

    typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [TICK_WIDTH-1:0]     tick;
        logic                      pin;
        bit                        typed;
        result_t                   want;
        logic [CFG_ADDR_WIDTH-1:0] addr;
        logic [CFG_WIDTH-1:0]      value;
    } plan_row_t;

    logic                        aclk;
    logic                        aresetn   = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    // [31:0] tick_now, [32] pin_level, rest zero
    logic [S_DATA_WIDTH-1:0]     s_tdata   = '0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    // [1:0] event_res, [2] stepped, rest zero
    logic [M_DATA_WIDTH-1:0]     m_tdata;
    logic                        cfg_wr_en = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0]   cfg_addr  = '0;
    logic [CFG_WIDTH-1:0]        cfg_wdata = '0;

    // Register copy held by the classifier model.
    logic [CFG_WIDTH-1:0]   hold_tgt     = HOLD_TICKS_RST;
    logic [CFG_WIDTH-1:0]   debounce_lim = DEBOUNCE_TICKS_RST;
    logic [CFG_WIDTH-1:0]   gap_lim      = DOUBLE_GAP_TICKS_RST;
    logic [CFG_WIDTH-1:0]   pace         = PACE_INTERVAL_RST;

    // Classifier state: all zero out of reset.
    logic [TICK_WIDTH-1:0]  last_tick      = '0;
    logic [COUNT_WIDTH-1:0] held_steps     = '0;
    logic [COUNT_WIDTH-1:0] released_steps = '0;
    logic [CLICK_WIDTH-1:0] pending_clicks = '0;

    // Events still to come out of the result channel, oldest first.
    result_t expected_events[$];
    plan_row_t plan[$];

    int steps_taken   = 0;
    int mismatches    = 0;
    int src_idle_pct  = 14;
    int sink_idle_pct = 62;

    button_click_hold_classifier_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run one paced step of the classifier on an accepted word and return the
    // event it raises. Words that arrive before the pacing interval has passed
    // leave the state alone and report no step.
    function automatic result_t classify_step(input logic [TICK_WIDTH-1:0] tick,
                                              input logic pin);
        result_t               r;
        logic [TICK_WIDTH-1:0] diff;
        r.event_res = EV_NONE;
        r.stepped   = 1'b0;
        diff = tick - last_tick;
        if (diff >= TICK_WIDTH'(pace)) begin
            r.stepped = 1'b1;
            steps_taken++;
            last_tick = tick;
            if (!pin) begin
                // Pressed: count up to saturation, flag a hold exactly once.
                released_steps = '0;
                if (held_steps < COUNT_MAX) begin
                    held_steps = held_steps + 1'b1;
                    if (held_steps == hold_tgt) begin
                        r.event_res    = EV_HOLD;
                        pending_clicks = '0;
                    end
                end
            end else begin
                // Released: a press inside the debounce/hold window is a click.
                if (held_steps != '0) begin
                    if (held_steps > debounce_lim && held_steps < hold_tgt)
                        pending_clicks = pending_clicks + 1'b1;
                    held_steps = '0;
                end
                if (pending_clicks != '0) begin
                    if (released_steps < COUNT_MAX)
                        released_steps = released_steps + 1'b1;
                    if (pending_clicks == 2'd2) begin
                        r.event_res    = EV_DOUBLE;
                        pending_clicks = '0;
                        released_steps = '0;
                    end else if (released_steps > gap_lim) begin
                        if (pending_clicks == 2'd1)
                            r.event_res = EV_SINGLE;
                        pending_clicks = '0;
                        released_steps = '0;
                    end
                end else begin
                    released_steps = '0;
                end
            end
        end
        return r;
    endfunction

    function automatic plan_row_t sample_row(input logic [TICK_WIDTH-1:0] tick,
                                             input logic pin, input bit typed = 1'b0,
                                             input logic [EVENT_WIDTH-1:0] ev = EV_NONE,
                                             input logic st = 1'b0);
        plan_row_t row;
        row.kind            = ROW_SAMPLE;
        row.tick            = tick;
        row.pin             = pin;
        row.typed           = typed;
        row.want.event_res  = ev;
        row.want.stepped    = st;
        row.addr            = '0;
        row.value           = '0;
        return row;
    endfunction

    function automatic plan_row_t write_row(input logic [CFG_ADDR_WIDTH-1:0] addr,
                                            input logic [CFG_WIDTH-1:0] value);
        plan_row_t row;
        row         = sample_row('0, 1'b1);
        row.kind    = ROW_WRITE;
        row.addr    = addr;
        row.value   = value;
        return row;
    endfunction

    // Drop valid and hold until every expected event has come back.
    task automatic wait_quiet;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_events.size() != 0);
    endtask

    // Write one register with the pipeline empty, then mirror it in the model.
    task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] addr,
                             input logic [CFG_WIDTH-1:0] value);
        wait_quiet();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_HOLD_TICKS:       hold_tgt     = value;
            REG_DEBOUNCE_TICKS:   debounce_lim = value;
            REG_DOUBLE_GAP_TICKS: gap_lim      = value;
            REG_PACE_INTERVAL:    pace         = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [CFG_WIDTH-1:0] hold,
                                input logic [CFG_WIDTH-1:0] debounce,
                                input logic [CFG_WIDTH-1:0] gap,
                                input logic [CFG_WIDTH-1:0] interval);
        write_reg(REG_HOLD_TICKS, hold);
        write_reg(REG_DEBOUNCE_TICKS, debounce);
        write_reg(REG_DOUBLE_GAP_TICKS, gap);
        write_reg(REG_PACE_INTERVAL, interval);
    endtask

    // Offer one word, idling at random first; on accept, queue its event.
    // A typed expectation replaces the model's, but the model still advances.
    task automatic send_sample(input logic [TICK_WIDTH-1:0] tick, input logic pin,
                               input bit typed = 1'b0, input result_t want = '0);
        result_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_WIDTH - TICK_WIDTH - 1){1'b0}}, pin, tick};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = classify_step(tick, pin);
        expected_events.push_back(typed ? want : predicted);
    endtask

    // One paced step at the given pin level, sometimes preceded by a bounce:
    // a word inside the pacing interval that the block must ignore.
    task automatic paced_sample(input logic pin);
        logic [TICK_WIDTH-1:0] tick;
        if (pace > 1 && $urandom_range(0, 99) < 12)
            send_sample(last_tick + $urandom_range(0, pace - 1), 1'($urandom_range(0, 1)));
        tick = last_tick + pace + $urandom_range(0, 2);
        // Jump far ahead now and then so the tick count wraps.
        if ($urandom_range(0, 99) < 4)
            tick = tick + $urandom;
        send_sample(tick, pin);
    endtask

    // Result side: stall at random, check every accepted word in order.
    initial begin
        result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: expected none, got event %0d stepped %0d",
                             $time, m_tdata[EVENT_WIDTH-1:0], m_tdata[EVENT_WIDTH]);
                end else begin
                    want = expected_events.pop_front();
                    if (m_tdata[EVENT_WIDTH-1:0] !== want.event_res) begin
                        mismatches++;
                        $display("%0t: event_res mismatch: expected %0d, got %0d",
                                 $time, want.event_res, m_tdata[EVENT_WIDTH-1:0]);
                    end
                    if (m_tdata[EVENT_WIDTH] !== want.stepped) begin
                        mismatches++;
                        $display("%0t: stepped mismatch: expected %0d, got %0d",
                                 $time, want.stepped, m_tdata[EVENT_WIDTH]);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #1600000;
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        int base;
        int kind;
        int press_span;
        int release_span;
        int press_len;
        int release_len;

        // Directed part, reset values first: pace 10, debounce 3, hold 500, gap 30.
        plan.push_back(sample_row(32'd0, 1'b1, 1'b1, EV_NONE, 1'b0));   // too soon after reset
        plan.push_back(sample_row(32'd10, 1'b0, 1'b1, EV_NONE, 1'b1));  // exactly one interval
        plan.push_back(sample_row(32'hFFFF_FFFF, 1'b0, 1'b1, EV_NONE, 1'b1));
        plan.push_back(sample_row(32'd8, 1'b0, 1'b1, EV_NONE, 1'b0));   // wrapped, one short
        plan.push_back(sample_row(32'd9, 1'b0));
        plan.push_back(sample_row(32'd19, 1'b0));
        plan.push_back(sample_row(32'd29, 1'b1));                       // first click
        plan.push_back(sample_row(32'd39, 1'b0));
        plan.push_back(sample_row(32'd49, 1'b0));
        plan.push_back(sample_row(32'd59, 1'b0));
        plan.push_back(sample_row(32'd69, 1'b0));
        plan.push_back(sample_row(32'd79, 1'b1));                       // second click: double
        // Zero pacing, zero debounce and gap, hold after two steps.
        plan.push_back(write_row(REG_HOLD_TICKS, 16'd2));
        plan.push_back(write_row(REG_DEBOUNCE_TICKS, 16'd0));
        plan.push_back(write_row(REG_DOUBLE_GAP_TICKS, 16'd0));
        plan.push_back(write_row(REG_PACE_INTERVAL, 16'd0));
        plan.push_back(sample_row(32'd79, 1'b0));
        plan.push_back(sample_row(32'd79, 1'b1));                       // single at once
        plan.push_back(sample_row(32'd79, 1'b0));
        plan.push_back(sample_row(32'd79, 1'b0));                       // hold
        plan.push_back(sample_row(32'd79, 1'b1));                       // too long, no click
        // Zero hold target: no hold and no click.
        plan.push_back(write_row(REG_HOLD_TICKS, 16'd0));
        plan.push_back(sample_row(32'd0, 1'b0));
        plan.push_back(sample_row(32'd0, 1'b1));
        // Every register at its top value.
        plan.push_back(write_row(REG_HOLD_TICKS, 16'hFFFF));
        plan.push_back(write_row(REG_DEBOUNCE_TICKS, 16'hFFFF));
        plan.push_back(write_row(REG_DOUBLE_GAP_TICKS, 16'hFFFF));
        plan.push_back(write_row(REG_PACE_INTERVAL, 16'hFFFF));
        plan.push_back(sample_row(32'd65534, 1'b0));
        plan.push_back(sample_row(32'd65535, 1'b0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].addr, plan[i].value);
            else
                send_sample(plan[i].tick, plan[i].pin, plan[i].typed, plan[i].want);
        end

        // Random part: press/release gestures sized around the current targets.
        base = steps_taken;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                3: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                6: program_regs(16'd0, 16'd0, 16'd0, 16'd0);
                default: begin
                    kind = $urandom_range(0, 3);
                    program_regs(16'($urandom_range(1, 12)), 16'($urandom_range(0, 3)),
                                 16'($urandom_range(0, 6)),
                                 (kind == 0) ? 16'd0 :
                                 (kind == 1) ? 16'd1 :
                                 (kind == 2) ? 16'($urandom_range(2, 40)) : 16'hFFFF);
                end
            endcase
            while (steps_taken < base + (ph + 1) * TARGET_STEPS / PHASES) begin
                // Sender idles lightly first, then the receiver, then neither.
                if (steps_taken < base + TARGET_STEPS / 3) begin
                    src_idle_pct  = 14;
                    sink_idle_pct = 62;
                end else if (steps_taken < base + 2 * TARGET_STEPS / 3) begin
                    src_idle_pct  = 62;
                    sink_idle_pct = 14;
                end else begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
                press_span   = (hold_tgt == 0 || hold_tgt > 20) ? 20 : hold_tgt + 1;
                release_span = (gap_lim > 20) ? 20 : gap_lim + 2;
                kind = $urandom_range(0, 99);
                if (kind < 80) begin
                    // Well-formed press then release.
                    press_len   = $urandom_range(1, press_span);
                    release_len = $urandom_range(1, release_span);
                    repeat (press_len) paced_sample(1'b0);
                    repeat (release_len) paced_sample(1'b1);
                end else if (kind < 95) begin
                    // Noise: random ticks and levels.
                    repeat ($urandom_range(1, 5))
                        send_sample($urandom, 1'($urandom_range(0, 1)));
                end else begin
                    // Broken gesture: a press cut short by an early release.
                    paced_sample(1'b0);
                    paced_sample(1'b1);
                end
                // Let the pipeline run dry now and then.
                if ($urandom_range(0, 99) < 2)
                    wait_quiet();
            end
        end

        wait_quiet();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bcc_pkg.sv
design/bcc_cfg_regs.sv
design/bcc_step.sv
design/button_click_hold_classifier_top.sv
bench/tb.sv
